// ----- hdl/bavg_pkg.sv -----
`timescale 1ns / 1ps

package bavg_pkg;

    localparam int MAX_FACTOR = 16;
    localparam int FACTOR_W   = 5;
    localparam int NCHAN      = 6;
    localparam int CH_W       = 16;
    localparam int TIME_W     = 64;
    localparam int SUM_W      = CH_W + $clog2(MAX_FACTOR);
    localparam int MAG_W      = SUM_W + 1;
    localparam int DIGIT_W    = 8;
    localparam int TIME_STEPS = TIME_W / DIGIT_W;
    localparam int CH_STEPS   = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    localparam int CH_BITS    = CH_STEPS * DIGIT_W;
    localparam int WORD_W     = TIME_W + NCHAN * CH_W;
    localparam int IDX_W      = $clog2(NCHAN + 1);
    localparam int STEP_W     = $clog2(TIME_STEPS);

    localparam logic [CH_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [CH_W-1:0] SAT_NEG = 16'h8000;

    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [TIME_W-1:0]      start_time;
        logic [TIME_W-1:0]      offset_sum;
        t_sum [NCHAN-1:0]       sums;
        logic [FACTOR_W-1:0]    factor;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_DIV,
        B_STORE,
        B_OUT
    } t_bstate;

endpackage

// ----- hdl/block_average_decimator.sv -----
`timescale 1ns / 1ps
// The front takes one word per cycle while the two-entry block queue has room.
// A finished block goes through the queue to the back end, which runs B_LOAD, B_DIV, B_STORE
// for the time and then each channel on one shared divider, 8 quotient bits per cycle, then
// B_OUT loads the output register. The front gathers later blocks while the queue has room.
// Reset is synchronous and active low; it clears the block, the queue and sets the factor to 1.

module block_average_decimator import bavg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [FACTOR_W-1:0] i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // sample_time, acc_x, acc_y, acc_z, gyr_x, gyr_y, gyr_z
    input  logic [WORD_W-1:0]   s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // avg_time, avg_acc_x, avg_acc_y, avg_acc_z, avg_gyr_x, avg_gyr_y, avg_gyr_z
    output logic [WORD_W-1:0]   m_axis_tdata
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job pop_job;

    bavg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_word      (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    bavg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    bavg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (pop_job),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_word    (m_axis_tdata)
    );

endmodule

// ----- hdl/bavg_front.sv -----
`timescale 1ns / 1ps

module bavg_front import bavg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [FACTOR_W-1:0] i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [WORD_W-1:0]   i_word,
    input  logic                i_q_full,
    output logic                o_push,
    output t_job                o_job
);

    logic [FACTOR_W-1:0] r_factor;
    logic [FACTOR_W-1:0] n_factor;
    logic [FACTOR_W-1:0] r_count;
    logic [FACTOR_W-1:0] n_count;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   n_start;
    logic [TIME_W-1:0]   r_off;
    logic [TIME_W-1:0]   n_off;
    t_sum [NCHAN-1:0]    r_sums;
    t_sum [NCHAN-1:0]    n_sums;
    logic [TIME_W-1:0]   sample_time;
    logic [CH_W-1:0]     ch;
    logic                accept;
    logic                last;

    assign o_ready     = !i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign sample_time = i_word[TIME_W-1:0];

    always_comb begin
        n_factor = r_factor;
        if (i_cfg_wen) begin
            if (i_cfg_wdata == '0) begin
                n_factor = FACTOR_W'(1);
            end else if (i_cfg_wdata > FACTOR_W'(MAX_FACTOR)) begin
                n_factor = FACTOR_W'(MAX_FACTOR);
            end else begin
                n_factor = i_cfg_wdata;
            end
        end
    end

    always_comb begin
        ch      = '0;
        n_start = (r_count == '0) ? sample_time : r_start;
        n_off   = r_off + (sample_time - n_start);
        for (int i = 0; i < NCHAN; i++) begin
            ch        = i_word[TIME_W + i*CH_W +: CH_W];
            n_sums[i] = r_sums[i] + {{(SUM_W-CH_W){ch[CH_W-1]}}, ch};
        end
        n_count = r_count + FACTOR_W'(1);
        last    = (n_count >= r_factor);

        o_push           = accept && last;
        o_job.start_time = n_start;
        o_job.offset_sum = n_off;
        o_job.sums       = n_sums;
        o_job.factor     = r_factor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_W'(1);
            r_count  <= '0;
            r_start  <= '0;
            r_off    <= '0;
            r_sums   <= '0;
        end else begin
            r_factor <= n_factor;
            if (i_cfg_wen || (accept && last)) begin
                r_count <= '0;
                r_start <= '0;
                r_off   <= '0;
                r_sums  <= '0;
            end else if (accept) begin
                r_count <= n_count;
                r_start <= n_start;
                r_off   <= n_off;
                r_sums  <= n_sums;
            end
        end
    end

endmodule

// ----- hdl/bavg_queue.sv -----
`timescale 1ns / 1ps

module bavg_queue import bavg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- hdl/bavg_back.sv -----
`timescale 1ns / 1ps

module bavg_back import bavg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_job              i_q_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_word
);

    t_bstate             r_state;
    t_bstate             n_state;
    t_job                r_job;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    n_idx;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic [TIME_W-1:0]   r_div;
    logic [TIME_W-1:0]   n_div;
    logic [TIME_W-1:0]   r_q;
    logic [TIME_W-1:0]   n_q;
    logic [FACTOR_W-1:0] r_rem;
    logic [FACTOR_W-1:0] n_rem;
    logic                r_neg;
    logic                n_neg;
    logic [TIME_W-1:0]   r_res_time;
    logic [CH_W-1:0]     r_res_ch [NCHAN];
    logic [CH_W-1:0]     sat;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic                load_job;
    logic                load_out;
    logic                store;
    logic [IDX_W-1:0]    ch_sel;
    t_sum                sum;
    logic [MAG_W-1:0]    mag;
    logic [FACTOR_W-1:0] t;
    logic [DIGIT_W-1:0]  digit;

    assign o_valid = r_out_valid;
    assign o_word  = r_out_word;
    assign ch_sel  = r_idx - IDX_W'(1);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_step   = r_step;
        n_div    = r_div;
        n_q      = r_q;
        n_rem    = r_rem;
        n_neg    = r_neg;
        load_job = 1'b0;
        load_out = 1'b0;
        store    = 1'b0;
        o_pop    = 1'b0;
        sum      = r_job.sums[ch_sel];
        mag      = {sum[SUM_W-1], sum};
        t        = '0;
        digit    = '0;
        sat      = '0;

        if (r_neg) begin
            sat = (r_q > TIME_W'(32768)) ? SAT_NEG : CH_W'(~r_q[CH_W-1:0] + CH_W'(1));
        end else begin
            sat = (r_q > TIME_W'(32767)) ? SAT_POS : r_q[CH_W-1:0];
        end

        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    o_pop    = 1'b1;
                    load_job = 1'b1;
                    n_idx    = '0;
                    n_state  = B_LOAD;
                end
            end
            B_LOAD: begin
                n_rem = '0;
                n_q   = '0;
                if (r_idx == '0) begin
                    n_div  = r_job.offset_sum + TIME_W'(r_job.factor >> 1);
                    n_step = STEP_W'(TIME_STEPS - 1);
                    n_neg  = 1'b0;
                end else begin
                    n_neg = sum[SUM_W-1];
                    if (sum[SUM_W-1]) begin
                        mag = ~mag + MAG_W'(1);
                    end
                    mag    = mag + MAG_W'(r_job.factor >> 1);
                    n_div  = {CH_BITS'(mag), (TIME_W-CH_BITS)'(0)};
                    n_step = STEP_W'(CH_STEPS - 1);
                end
                n_state = B_DIV;
            end
            B_DIV: begin
                n_rem = r_rem;
                for (int k = 0; k < DIGIT_W; k++) begin
                    t = {n_rem[FACTOR_W-2:0], r_div[TIME_W-1-k]};
                    if (t >= r_job.factor) begin
                        t = t - r_job.factor;
                        digit[DIGIT_W-1-k] = 1'b1;
                    end
                    n_rem = t;
                end
                n_div = r_div << DIGIT_W;
                n_q   = {r_q[TIME_W-DIGIT_W-1:0], digit};
                if (r_step == '0) begin
                    n_state = B_STORE;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            B_STORE: begin
                store = 1'b1;
                if (r_idx == IDX_W'(NCHAN)) begin
                    n_state = B_OUT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = B_LOAD;
                end
            end
            B_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_step <= n_step;
        r_div  <= n_div;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        if (load_job) begin
            r_job <= i_q_job;
        end
        if (store) begin
            if (r_idx == '0) begin
                r_res_time <= r_job.start_time + r_q;
            end else begin
                r_res_ch[ch_sel] <= sat;
            end
        end
        if (load_out) begin
            r_out_word[TIME_W-1:0] <= r_res_time;
            for (int i = 0; i < NCHAN; i++) begin
                r_out_word[TIME_W + i*CH_W +: CH_W] <= r_res_ch[i];
            end
        end
    end

endmodule

// ----- tb/tb_block_average_decimator.sv -----
`timescale 1ns / 1ps

module tb_block_average_decimator;
    import bavg_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_WAIT = 13;
    localparam int MEAN_HI = 2 ** (CH_W - 1) - 1;
    localparam int MEAN_LO_MAG = 2 ** (CH_W - 1);

    // One word on either stream: channel 0 sits just above the time stamp.
    typedef struct packed {
        logic [NCHAN-1:0][CH_W-1:0] chan;
        logic [TIME_W-1:0]          stamp;
    } imu_word_t;

    class block_mean_tracker;
        int unsigned   factor;
        int unsigned   taken;
        bit [TIME_W-1:0] first_stamp;
        bit [TIME_W-1:0] offset_sum;
        int            chan_sum [NCHAN];
        imu_word_t     pending_means [$];
        int            errors;

        function new();
            factor = 1;
            errors = 0;
            clear_block();
        endfunction

        function void clear_block();
            taken = 0;
            first_stamp = '0;
            offset_sum = '0;
            foreach (chan_sum[i]) chan_sum[i] = 0;
        endfunction

        function void set_factor(logic [FACTOR_W-1:0] code);
            if (code == 0) factor = 1;
            else if (code > MAX_FACTOR) factor = MAX_FACTOR;
            else factor = code;
            clear_block();
        endfunction

        function logic [CH_W-1:0] round_mean(int sum, int n);
            int mag;
            if (sum >= 0) begin
                mag = (sum + n / 2) / n;
                return (mag > MEAN_HI) ? SAT_POS : CH_W'(mag);
            end
            mag = (-sum + n / 2) / n;
            return (mag > MEAN_LO_MAG) ? SAT_NEG : CH_W'(-mag);
        endfunction

        function void take_sample(imu_word_t w);
            imu_word_t mean;
            bit [TIME_W-1:0] n64;
            if (taken == 0) first_stamp = w.stamp;
            offset_sum += w.stamp - first_stamp;
            for (int i = 0; i < NCHAN; i++) chan_sum[i] += $signed(w.chan[i]);
            taken++;
            if (taken < factor) return;
            n64 = factor;
            mean.stamp = first_stamp + (offset_sum + n64 / 2) / n64;
            for (int i = 0; i < NCHAN; i++) mean.chan[i] = round_mean(chan_sum[i], factor);
            pending_means.push_back(mean);
            clear_block();
        endfunction

        function void check_mean(imu_word_t got);
            string names [NCHAN] = '{"avg_acc_x", "avg_acc_y", "avg_acc_z",
                                     "avg_gyr_x", "avg_gyr_y", "avg_gyr_z"};
            imu_word_t want;
            if (pending_means.size() == 0) begin
                $error("Unexpected output word: avg_time %0d", got.stamp);
                errors++;
                return;
            end
            want = pending_means.pop_front();
            if (want.stamp !== got.stamp) begin
                $error("avg_time: expected %0d, actual %0d", want.stamp, got.stamp);
                errors++;
            end
            for (int i = 0; i < NCHAN; i++) begin
                if (want.chan[i] !== got.chan[i]) begin
                    $error("%s: expected %0d, actual %0d", names[i],
                           $signed(want.chan[i]), $signed(got.chan[i]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wen = 1'b0;
    logic [FACTOR_W-1:0] i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [WORD_W-1:0]   m_axis_tdata;

    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    block_mean_tracker tracker = new();

    block_average_decimator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) tracker.take_sample(imu_word_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) tracker.check_mean(imu_word_t'(m_axis_tdata));
        end
    end

    initial begin
        int stall;
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    function automatic imu_word_t flat_word(logic [TIME_W-1:0] stamp, logic [CH_W-1:0] v);
        imu_word_t w;
        w.stamp = stamp;
        for (int i = 0; i < NCHAN; i++) w.chan[i] = v;
        return w;
    endfunction

    function automatic imu_word_t striped_word(logic [TIME_W-1:0] stamp,
                                               logic [CH_W-1:0] even, logic [CH_W-1:0] odd);
        imu_word_t w;
        w.stamp = stamp;
        for (int i = 0; i < NCHAN; i++) w.chan[i] = (i % 2 == 0) ? even : odd;
        return w;
    endfunction

    function automatic logic [TIME_W-1:0] advance_stamp(logic [TIME_W-1:0] prev);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return {$urandom, $urandom};
        if (pick < 5) return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3000));
        if (pick < 7) return prev - TIME_W'($urandom_range(1, 500));
        return prev + TIME_W'($urandom_range(1, 2500));
    endfunction

    function automatic logic [CH_W-1:0] draw_channel(logic [CH_W-1:0] level);
        int pick;
        logic [CH_W-1:0] corner [5];
        corner = '{SAT_NEG, SAT_POS, 16'hFFFF, 16'h0000, 16'h0001};
        pick = $urandom_range(0, 9);
        if (pick < 5) return CH_W'($urandom);
        if (pick < 7) return corner[$urandom_range(0, 4)];
        return level + CH_W'($urandom_range(0, 4)) - CH_W'(2);
    endfunction

    task automatic send_word(input imu_word_t w);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_means();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_means.size() != 0);
    endtask

    // A block in progress may still be inside the divider, so wait it out before writing.
    task automatic load_factor(input logic [FACTOR_W-1:0] code);
        drain_means();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        tracker.set_factor(code);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        logic [FACTOR_W-1:0] odd_codes [5];
        logic [FACTOR_W-1:0] code;
        logic [TIME_W-1:0]   stamp;
        logic [CH_W-1:0]     level;
        imu_word_t           w;
        int                  sent;
        int                  phase;
        int                  total;

        odd_codes = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(flat_word({TIME_W{1'b1}}, SAT_POS));
        send_word(flat_word('0, SAT_NEG));
        send_word(striped_word({16{4'h5}}, 16'h5555, 16'hAAAA));
        send_word(striped_word({16{4'hA}}, 16'hAAAA, 16'h5555));

        load_factor(5'd0);
        send_word(flat_word(64'd123, 16'h0000));

        // Halves round away from zero; the second word's time wraps past zero.
        load_factor(5'd2);
        send_word(flat_word(64'hFFFF_FFFF_FFFF_FFFE, 16'h0001));
        send_word(flat_word(64'd2, 16'h0000));
        send_word(flat_word(64'd10, 16'hFFFF));
        send_word(flat_word(64'd11, 16'h0000));
        send_word(flat_word(64'd20, SAT_POS));
        send_word(flat_word(64'd21, SAT_POS));
        send_word(flat_word(64'd30, SAT_NEG));

        load_factor(5'd3);
        send_word(flat_word(64'd100, 16'h0001));
        send_word(flat_word(64'd90, 16'h0001));
        send_word(flat_word(64'd95, 16'h0000));

        load_factor(5'd31);
        send_word(flat_word(64'd500, SAT_NEG));
        load_factor(5'd17);
        send_word(flat_word(64'd600, SAT_POS));

        sent = 0;
        phase = 0;
        stamp = {$urandom, $urandom};
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) code = odd_codes[$urandom_range(0, 4)];
            else code = FACTOR_W'($urandom_range(1, MAX_FACTOR));
            load_factor(code);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            level = CH_W'($urandom);
            total = tracker.factor * $urandom_range(1, 6)
                    + $urandom_range(0, tracker.factor - 1);
            for (int k = 0; k < total; k++) begin
                if (phase == 2 && k == total / 2) drain_means();
                stamp = advance_stamp(stamp);
                w.stamp = stamp;
                for (int c = 0; c < NCHAN; c++) w.chan[c] = draw_channel(level);
                send_word(w);
            end
            sent += total;
            phase++;
        end

        drain_means();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
